### sv/pcm_to_dsd_modulator_core_macros.svh
// assertion macros for the pcm to dsd modulator core
`ifndef PCM_TO_DSD_MODULATOR_CORE_MACROS_SVH
`define PCM_TO_DSD_MODULATOR_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define PCMDSD_ASSERT(name, clk, rst_n, prop) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("pcm_to_dsd_modulator_core: check failed");
`define PCMDSD_ASSERT_NEVER(name, clk, rst_n, cond) \
	`PCMDSD_ASSERT(name, clk, rst_n, !(cond))
`else
`define PCMDSD_ASSERT(name, clk, rst_n, prop)
`define PCMDSD_ASSERT_NEVER(name, clk, rst_n, cond)
`endif

`endif

### sv/pcmdsd_pkg.sv
`default_nettype none

package pcmdsd_pkg;

	localparam int CFG_BITS   = 7;
	localparam int RATE_MIN   = 8;
	localparam int RATE_RESET = 64;
	localparam int BYTE_BITS  = 8;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_INIT,
		ST_ERR,
		ST_SEC,
		ST_DFB,
		ST_FIR,
		ST_ADV
	} pcmdsd_state_t;

	typedef struct packed {
		logic valid;
		logic value;
		logic tail;
		logic clear;
	} pcmdsd_bit_t;

endpackage

`default_nettype wire

### sv/pcmdsd_pcm_if.sv
`default_nettype none

interface pcmdsd_pcm_if #(
	parameter int SAMPLE_BITS = 24
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample;
	logic                          end_of_stream;

	modport source (output valid, output sample, output end_of_stream, input ready);
	modport sink (input valid, input sample, input end_of_stream, output ready);
endinterface

`default_nettype wire

### sv/pcmdsd_dsd_if.sv
`default_nettype none

interface pcmdsd_dsd_if;
	logic       valid;
	logic       ready;
	logic [7:0] dsd_byte;
	logic       last_byte;

	modport source (output valid, output dsd_byte, output last_byte, input ready);
	modport sink (input valid, input dsd_byte, input last_byte, output ready);
endinterface

`default_nettype wire

### sv/pcmdsd_alu.sv
`default_nettype none

module pcmdsd_alu #(
	parameter int SW = 49,
	parameter int IW = 48
) (
	input  wire logic signed [SW-1:0] a,
	input  wire logic signed [SW-1:0] b,
	output logic signed [SW-1:0]      sum,
	output logic signed [IW-1:0]      sat
);

	localparam logic signed [SW-1:0] HI = {{(SW-IW+1){1'b0}}, {(IW-1){1'b1}}};
	localparam logic signed [SW-1:0] LO = {{(SW-IW+1){1'b1}}, {(IW-1){1'b0}}};

	always_comb begin
		sum = a + b;
		if (sum > HI) begin
			sat = HI[IW-1:0];
		end else if (sum < LO) begin
			sat = LO[IW-1:0];
		end else begin
			sat = sum[IW-1:0];
		end
	end

endmodule

`default_nettype wire

### sv/pcmdsd_packer.sv
`default_nettype none

module pcmdsd_packer
	import pcmdsd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire pcmdsd_bit_t bit_req,
	output logic             bit_ready,
	pcmdsd_dsd_if.source     dsd
);

	logic [BYTE_BITS-1:0] pack_q;
	logic [2:0]           cnt_q;
	logic                 out_valid_q;
	logic [BYTE_BITS-1:0] out_byte_q;
	logic                 out_last_q;
	logic                 take;
	logic                 full;
	logic [BYTE_BITS-1:0] shifted;

	always_comb begin
		full      = (cnt_q == 3'd7);
		bit_ready = !full || !out_valid_q || dsd.ready;
		take      = bit_req.valid && bit_ready;
		shifted   = {pack_q[BYTE_BITS-2:0], bit_req.value};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pack_q      <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				if (bit_req.clear || full) begin
					pack_q <= '0;
				end else begin
					pack_q <= shifted;
				end
				if (bit_req.clear) begin
					cnt_q <= '0;
				end else begin
					cnt_q <= cnt_q + 3'd1;
				end
			end
			if (take && full) begin
				out_valid_q <= 1'b1;
			end else if (dsd.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// completed byte
	always_ff @(posedge clk) begin
		if (take && full) begin
			out_byte_q <= shifted;
			out_last_q <= bit_req.tail;
		end
	end

	assign dsd.valid     = out_valid_q;
	assign dsd.dsd_byte  = out_byte_q;
	assign dsd.last_byte = out_last_q;

endmodule

`default_nettype wire

### sv/pcm_to_dsd_modulator_core.sv
// pcm to dsd modulator core
// pcm is a valid/ready sink of signed samples with an end_of_stream flag;
// dsd is a valid/ready source of packed modulator bytes, earliest bit in
// bit 7, with last_byte on the final complete byte of a stream.
// upsample_rate is written through upsample_rate_we/upsample_rate_wdata
// by the user only while idle; the block does not enforce it. it is
// clamped to 8..MAX_RATE and latched per sample. the first sample of a
// stream is only held unless it has end_of_stream. every later sample
// runs one interpolated segment of R bits; a sample with end_of_stream
// runs a flat segment of R bits and clears the stream state, dropping a
// trailing partial byte. a segment is a multiply and a setup step, then
// four passes through the shared saturating adder per bit and one
// between bits to advance the interpolation. a sample is taken only
// while the sequencer is idle. a stalled receiver is absorbed by the
// output register; when a further byte completes, the sequencer waits
// on that bit until the register is taken. reset clears the stream
// state and sets upsample_rate to 64.
`default_nettype none
`include "pcm_to_dsd_modulator_core_macros.svh"

module pcm_to_dsd_modulator_core
	import pcmdsd_pkg::*;
#(
	parameter int SAMPLE_BITS     = 24,
	parameter int INTEGRATOR_BITS = 48,
	parameter int MAX_RATE        = 64
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                upsample_rate_we,
	input  wire logic [CFG_BITS-1:0] upsample_rate_wdata,
	pcmdsd_pcm_if.sink               pcm,
	pcmdsd_dsd_if.source             dsd
);

	localparam int RW = $clog2(MAX_RATE + 1);
	localparam int CW = (RW > CFG_BITS) ? RW : CFG_BITS;
	localparam int PW = SAMPLE_BITS + RW + 1;
	localparam int UW = SAMPLE_BITS + RW + 3;
	localparam int IW = INTEGRATOR_BITS;
	localparam int SW = ((IW > UW) ? IW : UW) + 1;
	localparam int DW = SAMPLE_BITS + 1;

	pcmdsd_state_t state_q, state_d;

	logic [CFG_BITS-1:0]           upsample_rate_q;
	logic [CW-1:0]                 cfg_ext;
	logic [RW-1:0]                 rate_eff;
	logic [RW-1:0]                 r_q;
	logic [RW-1:0]                 j_q;
	logic                          j_last;
	logic signed [SAMPLE_BITS-1:0] held_q;
	logic                          have_held_q;
	logic                          eos_q;
	logic                          flat_q;
	logic signed [SAMPLE_BITS-1:0] start_q;
	logic signed [SAMPLE_BITS-1:0] next_q;
	logic signed [PW-1:0]          prod_s1;
	logic signed [DW-1:0]          diff_q;
	logic signed [UW-1:0]          u_q;
	logic signed [SW-1:0]          t_q;
	logic signed [IW-1:0]          first_q;
	logic signed [IW-1:0]          second_q;
	logic                          fb_q;
	logic signed [SW-1:0]          fbv;
	logic signed [SW-1:0]          half;
	logic signed [SW-1:0]          alu_a;
	logic signed [SW-1:0]          alu_b;
	logic signed [SW-1:0]          alu_sum;
	logic signed [IW-1:0]          alu_sat;
	logic                          accept;
	logic                          bit_ready;
	logic                          bit_take;
	pcmdsd_bit_t                   bit_req;

	pcmdsd_alu #(
		.SW(SW),
		.IW(IW)
	) u_alu (
		.a  (alu_a),
		.b  (alu_b),
		.sum(alu_sum),
		.sat(alu_sat)
	);

	pcmdsd_packer u_packer (
		.clk      (clk),
		.arst_n   (arst_n),
		.bit_req  (bit_req),
		.bit_ready(bit_ready),
		.dsd      (dsd)
	);

	always_comb begin
		cfg_ext = CW'(upsample_rate_q);
		if (cfg_ext < CW'(RATE_MIN)) begin
			rate_eff = RW'(RATE_MIN);
		end else if (cfg_ext > CW'(MAX_RATE)) begin
			rate_eff = RW'(MAX_RATE);
		end else begin
			rate_eff = RW'(cfg_ext);
		end
	end

	always_comb begin
		fbv    = fb_q ? SW'({r_q, {SAMPLE_BITS{1'b0}}}) : '0;
		half   = SW'({r_q, {(SAMPLE_BITS-1){1'b0}}});
		j_last = (j_q == RW'(r_q - 1'b1));
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (pcm.valid && (have_held_q || pcm.end_of_stream)) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL:  state_d = ST_INIT;
			ST_INIT: state_d = ST_ERR;
			ST_ERR:  state_d = ST_SEC;
			ST_SEC:  state_d = ST_DFB;
			ST_DFB:  state_d = ST_FIR;
			ST_FIR: begin
				if (bit_ready) begin
					if (!j_last) begin
						state_d = ST_ADV;
					end else if (!flat_q && eos_q) begin
						state_d = ST_MUL;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_ADV:  state_d = ST_ERR;
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs and shared adder operands
	always_comb begin
		pcm.ready     = (state_q == ST_IDLE);
		bit_req.valid = (state_q == ST_FIR);
		bit_req.value = ~alu_sat[IW-1];
		bit_req.tail  = flat_q &&
			(({1'b0, j_q} + (RW+1)'(BYTE_BITS)) >= {1'b0, r_q});
		bit_req.clear = flat_q && j_last;
		alu_a         = '0;
		alu_b         = '0;
		case (state_q)
			ST_MUL: begin
				alu_a = SW'(next_q);
				alu_b = -SW'(start_q);
			end
			ST_INIT: begin
				alu_a = SW'(prod_s1);
				alu_b = half;
			end
			ST_ERR: begin
				alu_a = SW'(u_q);
				alu_b = -fbv;
			end
			ST_SEC: begin
				alu_a = SW'(second_q);
				alu_b = t_q;
			end
			ST_DFB: begin
				alu_a = SW'(second_q);
				alu_b = -fbv;
			end
			ST_FIR: begin
				alu_a = SW'(first_q);
				alu_b = t_q;
			end
			ST_ADV: begin
				alu_a = SW'(u_q);
				alu_b = SW'(diff_q);
			end
			default: begin
				alu_a = '0;
				alu_b = '0;
			end
		endcase
	end

	assign accept   = pcm.valid && pcm.ready;
	assign bit_take = bit_req.valid && bit_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			upsample_rate_q <= CFG_BITS'(RATE_RESET);
			held_q          <= '0;
			have_held_q     <= 1'b0;
			eos_q           <= 1'b0;
			flat_q          <= 1'b0;
			j_q             <= '0;
			first_q         <= '0;
			second_q        <= '0;
			fb_q            <= 1'b0;
		end else begin
			state_q <= state_d;
			if (upsample_rate_we) begin
				upsample_rate_q <= upsample_rate_wdata;
			end
			if (accept) begin
				held_q      <= pcm.sample;
				have_held_q <= 1'b1;
				eos_q       <= pcm.end_of_stream;
				flat_q      <= !have_held_q;
			end
			if (accept || (state_q == ST_INIT)) begin
				j_q <= '0;
			end
			if (state_q == ST_SEC) begin
				second_q <= alu_sat;
			end
			if (bit_take) begin
				if (j_last && flat_q) begin
					// end of stream
					held_q      <= '0;
					have_held_q <= 1'b0;
					eos_q       <= 1'b0;
					first_q     <= '0;
					second_q    <= '0;
					fb_q        <= 1'b0;
				end else begin
					first_q <= alu_sat;
					fb_q    <= ~alu_sat[IW-1];
					if (!j_last) begin
						j_q <= j_q + 1'b1;
					end else if (eos_q) begin
						flat_q <= 1'b1;
					end
				end
			end
		end
	end

	// segment datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			r_q     <= rate_eff;
			next_q  <= pcm.sample;
			start_q <= have_held_q ? held_q : pcm.sample;
		end
		if (bit_take && j_last && !flat_q && eos_q) begin
			start_q <= next_q;
		end
		case (state_q)
			ST_MUL: begin
				prod_s1 <= PW'($signed({1'b0, r_q})) * PW'(start_q);
				diff_q  <= alu_sum[DW-1:0];
			end
			ST_INIT: u_q <= alu_sum[UW-1:0];
			ST_ERR:  t_q <= alu_sum;
			ST_DFB:  t_q <= SW'(alu_sat);
			ST_ADV:  u_q <= alu_sum[UW-1:0];
			default: begin
			end
		endcase
	end

	`PCMDSD_ASSERT(a_bit_index_in_range, clk, arst_n, (state_q != ST_IDLE) |-> (j_q < r_q))
	`PCMDSD_ASSERT(a_stalled_bit_waits, clk, arst_n, (bit_req.valid && !bit_ready) |=> (state_q == ST_FIR))
	`PCMDSD_ASSERT_NEVER(a_rate_clamped, clk, arst_n, (state_q != ST_IDLE) && (r_q < RW'(RATE_MIN)))

endmodule

`default_nettype wire

### tb/sv/tb_pcm_to_dsd_modulator_core.sv
`timescale 1ns / 100ps

module tb_pcm_to_dsd_modulator_core;
	import pcmdsd_pkg::*;

	localparam int SAMPLE_BITS     = 24;
	localparam int INTEGRATOR_BITS = 48;
	localparam int MAX_RATE        = 64;
	localparam int SETTLE_CYCLES   = 2 * (5 * MAX_RATE + 1) + 16;
	localparam int RANDOM_ITEMS    = 160;

	typedef struct packed {
		logic [7:0] dsd_byte;
		logic       last_byte;
	} dsd_word_t;

	logic clk = 1'b0;
	logic arst_n;
	logic upsample_rate_we;
	logic [CFG_BITS-1:0] upsample_rate_wdata;

	pcmdsd_pcm_if #(.SAMPLE_BITS(SAMPLE_BITS)) pcm ();
	pcmdsd_dsd_if dsd ();

	pcm_to_dsd_modulator_core #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.INTEGRATOR_BITS(INTEGRATOR_BITS),
		.MAX_RATE(MAX_RATE)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.upsample_rate_we(upsample_rate_we),
		.upsample_rate_wdata(upsample_rate_wdata),
		.pcm(pcm),
		.dsd(dsd)
	);

	always #2 clk = ~clk;

	// modulator state mirrored from the block
	logic [CFG_BITS-1:0]          rate_reg = CFG_BITS'(RATE_RESET);
	logic signed [SAMPLE_BITS-1:0] held_sample = '0;
	logic                          have_held = 1'b0;
	longint                        first_integ = 0;
	longint                        second_integ = 0;
	logic                          feedback = 1'b0;
	logic [BYTE_BITS-1:0]          pack_reg = '0;
	logic [2:0]                    pack_cnt = '0;

	dsd_word_t dsd_expected[$];
	dsd_word_t dsd_want;
	int        fail_count = 0;
	bit        pcm_quiet = 1'b0;
	bit        dsd_quiet = 1'b0;
	int        dsd_hold_req = 0;

	function automatic int gap_len(input bit quiet);
		int pick;
		if (quiet)
			return 0;
		pick = $urandom_range(0, 99);
		if (pick < 40)
			return 0;
		if (pick < 80)
			return $urandom_range(1, 3);
		if (pick < 96)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic longint sat_integ(input longint a, input longint b);
		longint hi;
		longint lo;
		longint sum;
		hi = (longint'(1) <<< (INTEGRATOR_BITS - 1)) - 1;
		lo = -hi - 1;
		sum = a + b;
		if (sum > hi)
			return hi;
		if (sum < lo)
			return lo;
		return sum;
	endfunction

	task automatic clear_stream();
		held_sample = '0;
		have_held = 1'b0;
		first_integ = 0;
		second_integ = 0;
		feedback = 1'b0;
		pack_reg = '0;
		pack_cnt = '0;
	endtask

	task automatic modulate_segment(input longint start, input longint stop, input longint r);
		longint one;
		longint half;
		longint diff;
		longint fbv;
		longint u;
		longint j;
		one = r <<< SAMPLE_BITS;
		half = r <<< (SAMPLE_BITS - 1);
		diff = stop - start;
		for (j = 0; j < r; j++) begin
			fbv = feedback ? one : 0;
			u = r * start + j * diff + half;
			second_integ = sat_integ(second_integ, u - fbv);
			first_integ = sat_integ(first_integ, sat_integ(second_integ, -fbv));
			feedback = (first_integ >= 0);
			pack_reg = {pack_reg[6:0], feedback};
			pack_cnt = pack_cnt + 3'd1;
			if (pack_cnt == 3'd0) begin
				dsd_expected.push_back('{dsd_byte: pack_reg, last_byte: 1'b0});
				pack_reg = '0;
			end
		end
	endtask

	task automatic predict_bytes(input logic signed [SAMPLE_BITS-1:0] value, input logic eos);
		longint r;
		int n0;
		dsd_word_t w;
		r = longint'(rate_reg);
		if (r < RATE_MIN)
			r = RATE_MIN;
		if (r > MAX_RATE)
			r = MAX_RATE;
		n0 = dsd_expected.size();
		if (have_held)
			modulate_segment(longint'(held_sample), longint'(value), r);
		held_sample = value;
		have_held = 1'b1;
		if (eos) begin
			modulate_segment(longint'(value), longint'(value), r);
			if (dsd_expected.size() > n0) begin
				w = dsd_expected.pop_back();
				w.last_byte = 1'b1;
				dsd_expected.push_back(w);
			end
			clear_stream();
		end
	endtask

	task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] value, input logic eos);
		int gap;
		gap = gap_len(pcm_quiet);
		if (gap > 0) begin
			pcm.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pcm.valid <= 1'b1;
		pcm.sample <= value;
		pcm.end_of_stream <= eos;
		do @(posedge clk); while (pcm.ready !== 1'b1);
		predict_bytes(value, eos);
	endtask

	task automatic wait_drained();
		pcm.valid <= 1'b0;
		while (dsd_expected.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_rate(input logic [CFG_BITS-1:0] value);
		wait_drained();
		upsample_rate_we <= 1'b1;
		upsample_rate_wdata <= value;
		@(posedge clk);
		upsample_rate_we <= 1'b0;
		rate_reg = value;
	endtask

	task automatic test_reset_rate();
		send_sample(24'sd0, 1'b0);
		send_sample(24'sd8388607, 1'b0);
		send_sample(-24'sd8388608, 1'b0);
		send_sample(-24'sd1, 1'b0);
		send_sample(24'sd1, 1'b1);
	endtask

	task automatic test_single_sample();
		send_sample(24'sd8388607, 1'b1);
		send_sample(-24'sd8388608, 1'b1);
	endtask

	task automatic test_rate_settings();
		write_rate(7'd8);
		send_sample(24'sd123456, 1'b0);
		send_sample(-24'sd654321, 1'b1);
		write_rate(7'd0);
		send_sample(24'sd0, 1'b1);
		write_rate(7'd7);
		send_sample(-24'sd8388608, 1'b0);
		// new rate on a held stream, integrators carry over
		write_rate(7'd127);
		send_sample(24'sd8388607, 1'b1);
		write_rate(7'd65);
		send_sample(24'sd4096, 1'b0);
		send_sample(-24'sd4096, 1'b1);
		// rates that leave a partial byte behind
		write_rate(7'd13);
		send_sample(24'sd1, 1'b0);
		send_sample(24'sd2000000, 1'b1);
		write_rate(7'd64);
	endtask

	task automatic test_backpressure();
		int k;
		wait_drained();
		pcm_quiet = 1'b1;
		dsd_hold_req = 500;
		for (k = 0; k < 6; k++)
			send_sample(SAMPLE_BITS'($urandom), k == 5);
		pcm_quiet = 1'b0;
	endtask

	task automatic test_random_streams();
		int sent;
		int len;
		int mode;
		int k;
		int pick;
		longint walk;
		logic signed [SAMPLE_BITS-1:0] value;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			if ($urandom_range(0, 3) == 0) begin
				pick = $urandom_range(0, 9);
				if (pick < 6)
					write_rate(CFG_BITS'($urandom_range(8, 24)));
				else if (pick < 8)
					write_rate(CFG_BITS'($urandom_range(25, 64)));
				else if (pick == 8)
					write_rate(CFG_BITS'($urandom_range(0, 7)));
				else
					write_rate(CFG_BITS'($urandom_range(65, 127)));
			end
			pcm_quiet = ($urandom_range(0, 5) == 0);
			dsd_quiet = ($urandom_range(0, 5) == 0);
			len = $urandom_range(1, 10);
			mode = $urandom_range(0, 2);
			walk = longint'($signed(SAMPLE_BITS'($urandom)));
			for (k = 0; k < len; k++) begin
				case (mode)
					0: begin
						value = SAMPLE_BITS'($urandom);
					end
					1: begin
						walk = walk + longint'($urandom_range(0, 4000)) - 2000;
						if (walk > 8388607)
							walk = 8388607;
						if (walk < -8388608)
							walk = -8388608;
						value = SAMPLE_BITS'(walk);
					end
					default: begin
						pick = $urandom_range(0, 3);
						value = (pick == 0) ? 24'sd8388607 :
							(pick == 1) ? -24'sd8388608 :
							(pick == 2) ? 24'sd0 : -24'sd1;
					end
				endcase
				send_sample(value, k == len - 1);
				sent++;
			end
		end
		pcm_quiet = 1'b0;
		dsd_quiet = 1'b0;
	endtask

	initial begin : dsd_ready_gen
		int left;
		left = 0;
		dsd.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (dsd_hold_req > 0) begin
				left = dsd_hold_req;
				dsd_hold_req = 0;
			end else if (left == 0 && !dsd_quiet && $urandom_range(0, 3) == 0) begin
				left = gap_len(1'b0);
			end
			if (left > 0) begin
				dsd.ready <= 1'b0;
				left--;
			end else begin
				dsd.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1 && dsd.valid === 1'b1 && dsd.ready === 1'b1) begin
			if (dsd_expected.size() == 0) begin
				$display("%0t: unexpected transaction, actual byte=%02h last=%0b",
					$time, dsd.dsd_byte, dsd.last_byte);
				fail_count++;
			end else begin
				dsd_want = dsd_expected.pop_front();
				if (dsd.dsd_byte !== dsd_want.dsd_byte) begin
					$display("%0t: dsd_byte mismatch, expected=%02h actual=%02h",
						$time, dsd_want.dsd_byte, dsd.dsd_byte);
					fail_count++;
				end
				if (dsd.last_byte !== dsd_want.last_byte) begin
					$display("%0t: last_byte mismatch, expected=%0b actual=%0b",
						$time, dsd_want.last_byte, dsd.last_byte);
					fail_count++;
				end
			end
		end
	end

	initial begin
		arst_n <= 1'b0;
		upsample_rate_we <= 1'b0;
		upsample_rate_wdata <= '0;
		pcm.valid <= 1'b0;
		pcm.sample <= '0;
		pcm.end_of_stream <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_rate();
		test_single_sample();
		test_rate_settings();
		test_backpressure();
		test_random_streams();
		wait_drained();
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin
		#8_000_000;
		$display("status: fail");
		$finish;
	end

endmodule
